### rtl/nvc_pkg.sv
package nvc_pkg;

  // field widths
  localparam int unsigned OPCODE_W   = 8;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned LBA_W      = 64;
  localparam int unsigned NLB_W      = 16;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned PTR_W      = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned OFFSET_W   = 52;
  localparam int unsigned LENGTH_W   = 29;
  localparam int unsigned DEV_BLK_W  = 41;
  localparam int unsigned BLK_BYTES_W = 13;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 64;

  // command opcodes
  localparam logic [OPCODE_W-1:0] OP_FLUSH = 8'h00;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 8'h01;
  localparam logic [OPCODE_W-1:0] OP_READ  = 8'h02;

  // completion status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_OPCODE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FIELD  = 2'd2;

  // dma direction codes
  localparam logic [DIR_W-1:0] DIR_NONE     = 2'd0;
  localparam logic [DIR_W-1:0] DIR_TO_HOST  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_TO_DEV   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_BLOCKS    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBMISSION_DEPTH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPLETION_DEPTH = 8'd3;

  // configuration reset values
  localparam logic [DEV_BLK_W-1:0]   RST_DEVICE_BLOCKS = 41'd1048576;
  localparam logic [BLK_BYTES_W-1:0] RST_BLOCK_BYTES   = 13'd512;
  localparam logic [PTR_W-1:0]       RST_DEPTH         = 16'd64;

  typedef struct packed {
    logic [DEV_BLK_W-1:0]   device_blocks;
    logic [BLK_BYTES_W-1:0] block_bytes;
    logic [PTR_W-1:0]       submission_depth;
    logic [PTR_W-1:0]       completion_depth;
  } cfg_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ID_W-1:0]     command_id;
    logic [LBA_W-1:0]    first_lba;
    logic [NLB_W-1:0]    blocks_minus_one;
    logic [ADDR_W-1:0]   buffer_address;
  } cmd_t;

  // queue pointer view before advance
  typedef struct packed {
    logic [PTR_W-1:0] tail;
    logic [PTR_W-1:0] head;
    logic             phase;
  } ptr_t;

  typedef struct packed {
    logic [PTR_W-1:0]    completion_slot;
    logic [PTR_W-1:0]    head_report;
    logic [ID_W-1:0]     echo_id;
    logic [STATUS_W-1:0] status;
    logic                phase;
    logic [DIR_W-1:0]    dma_direction;
    logic [ADDR_W-1:0]   dma_host_address;
    logic [OFFSET_W-1:0] dma_device_offset;
    logic [LENGTH_W-1:0] dma_length;
  } cpl_t;

endpackage

### rtl/nvc_cfg_if.sv
interface nvc_cfg_if;
  import nvc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

### rtl/nvc_in_if.sv
interface nvc_in_if;
  import nvc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ID_W-1:0]     command_id;
  logic [LBA_W-1:0]    first_lba;
  logic [NLB_W-1:0]    blocks_minus_one;
  logic [ADDR_W-1:0]   buffer_address;

  modport source (output valid, opcode, command_id, first_lba, blocks_minus_one,
                  buffer_address, input ready);
  modport sink (input valid, opcode, command_id, first_lba, blocks_minus_one,
                buffer_address, output ready);
endinterface

### rtl/nvc_out_if.sv
interface nvc_out_if;
  import nvc_pkg::*;

  logic                valid;
  logic                ready;
  logic [PTR_W-1:0]    completion_slot;
  logic [PTR_W-1:0]    head_report;
  logic [ID_W-1:0]     echo_id;
  logic [STATUS_W-1:0] status;
  logic                phase;
  logic [DIR_W-1:0]    dma_direction;
  logic [ADDR_W-1:0]   dma_host_address;
  logic [OFFSET_W-1:0] dma_device_offset;
  logic [LENGTH_W-1:0] dma_length;

  modport source (output valid, completion_slot, head_report, echo_id, status, phase,
                  dma_direction, dma_host_address, dma_device_offset, dma_length,
                  input ready);
  modport sink (input valid, completion_slot, head_report, echo_id, status, phase,
                dma_direction, dma_host_address, dma_device_offset, dma_length,
                output ready);
endinterface

### rtl/nvc_cfg_regs.sv
module nvc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [nvc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [nvc_pkg::CFG_DATA_W-1:0] wr_data,
  output nvc_pkg::cfg_t                  cfg
);
  import nvc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // decode the register write, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_DEVICE_BLOCKS:    cfg_nxt.device_blocks    = wr_data[DEV_BLK_W-1:0];
        CFG_BLOCK_BYTES:      cfg_nxt.block_bytes      = wr_data[BLK_BYTES_W-1:0];
        CFG_SUBMISSION_DEPTH: cfg_nxt.submission_depth = wr_data[PTR_W-1:0];
        CFG_COMPLETION_DEPTH: cfg_nxt.completion_depth = wr_data[PTR_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_blocks    <= RST_DEVICE_BLOCKS;
      cfg_r.block_bytes      <= RST_BLOCK_BYTES;
      cfg_r.submission_depth <= RST_DEPTH;
      cfg_r.completion_depth <= RST_DEPTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

### rtl/nvc_queue_ptrs.sv
module nvc_queue_ptrs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic [nvc_pkg::PTR_W-1:0] sq_depth,
  input  logic [nvc_pkg::PTR_W-1:0] cq_depth,
  output nvc_pkg::ptr_t             ptrs
);
  import nvc_pkg::*;

  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic             phase_r, phase_nxt;
  logic [PTR_W:0]   tail_inc, head_inc;
  logic [PTR_W:0]   cq_limit, sq_limit;

  // a depth of zero acts as the full 16-bit range
  assign cq_limit = {(cq_depth == '0), cq_depth};
  assign sq_limit = {(sq_depth == '0), sq_depth};
  assign tail_inc = {1'b0, tail_r} + 1'b1;
  assign head_inc = {1'b0, head_r} + 1'b1;

  // wrap pointers, the tail wrap flips the phase
  always_comb begin
    tail_nxt  = tail_r;
    head_nxt  = head_r;
    phase_nxt = phase_r;
    if (advance) begin
      if (tail_inc >= cq_limit) begin
        tail_nxt  = '0;
        phase_nxt = ~phase_r;
      end else begin
        tail_nxt = tail_inc[PTR_W-1:0];
      end
      if (head_inc >= sq_limit) begin
        head_nxt = '0;
      end else begin
        head_nxt = head_inc[PTR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r  <= '0;
      head_r  <= '0;
      phase_r <= 1'b1;
    end else begin
      tail_r  <= tail_nxt;
      head_r  <= head_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign ptrs.tail  = tail_r;
  assign ptrs.head  = head_r;
  assign ptrs.phase = phase_r;
endmodule

### rtl/nvc_cmd_eval.sv
module nvc_cmd_eval (
  input  nvc_pkg::cmd_t cmd,
  input  nvc_pkg::cfg_t cfg,
  input  nvc_pkg::ptr_t ptrs,
  output nvc_pkg::cpl_t cpl
);
  import nvc_pkg::*;

  localparam int unsigned CNT_W  = NLB_W + 1;
  localparam int unsigned END_W  = DEV_BLK_W + 1;
  localparam int unsigned OPROD_W = DEV_BLK_W + BLK_BYTES_W;
  localparam int unsigned LPROD_W = CNT_W + BLK_BYTES_W;

  logic [CNT_W-1:0]   count;
  logic [END_W-1:0]   end_blk;
  logic               lba_high_zero;
  logic               range_ok;
  logic               is_rw;
  logic [OPROD_W-1:0] offset_prod;
  logic [LPROD_W-1:0] length_prod;

  // exact range check: start plus count must not pass the device size
  assign count         = {1'b0, cmd.blocks_minus_one} + 1'b1;
  assign lba_high_zero = (cmd.first_lba[LBA_W-1:DEV_BLK_W] == '0);
  assign end_blk       = {1'b0, cmd.first_lba[DEV_BLK_W-1:0]} + END_W'(count);
  assign range_ok      = lba_high_zero && (end_blk <= {1'b0, cfg.device_blocks});
  assign is_rw         = (cmd.opcode == OP_READ) || (cmd.opcode == OP_WRITE);

  // byte offset and length products
  assign offset_prod = OPROD_W'(cmd.first_lba[DEV_BLK_W-1:0]) * OPROD_W'(cfg.block_bytes);
  assign length_prod = LPROD_W'(count) * LPROD_W'(cfg.block_bytes);

  // status and dma request
  always_comb begin
    cpl.completion_slot   = ptrs.tail;
    cpl.head_report       = ptrs.head;
    cpl.echo_id           = cmd.command_id;
    cpl.phase             = ptrs.phase;
    cpl.status            = ST_OK;
    cpl.dma_direction     = DIR_NONE;
    cpl.dma_host_address  = '0;
    cpl.dma_device_offset = '0;
    cpl.dma_length        = '0;
    if (is_rw) begin
      if (!range_ok) begin
        cpl.status = ST_BAD_FIELD;
      end else begin
        cpl.dma_direction     = (cmd.opcode == OP_READ) ? DIR_TO_HOST : DIR_TO_DEV;
        cpl.dma_host_address  = cmd.buffer_address;
        cpl.dma_device_offset = offset_prod[OFFSET_W-1:0];
        cpl.dma_length        = length_prod[LENGTH_W-1:0];
      end
    end else if (cmd.opcode != OP_FLUSH) begin
      cpl.status = ST_BAD_OPCODE;
    end
  end
endmodule

### rtl/nvme_io_command_completer.sv
// channel  | dir | handshake    | contents
// cfg_ch   | in  | valid/ready  | reg_index, wr_data (always ready)
// in_ch    | in  | valid/ready  | one fetched submission entry
// out_ch   | out | valid/ready  | one completion plus dma request
//
// one command per cycle sustained unless out_ch stalls; an accepted command goes
// through the input register, then evaluation into the result register
// the 41x13 offset multiply sets the critical path between the two registers
// synchronous active-low reset: queue pointers zero, phase one, config defaults
// a stalled output holds its entry; the input register keeps accepting until full
module nvme_io_command_completer (
  input logic        clk,
  input logic        rst_n,
  nvc_cfg_if.sink    cfg_ch,
  nvc_in_if.sink     in_ch,
  nvc_out_if.source  out_ch
);
  import nvc_pkg::*;

  cfg_t cfg;
  ptr_t ptrs;
  cpl_t cpl;
  cmd_t in_cmd;

  logic s1_valid_r, s1_valid_nxt;
  cmd_t s1_cmd_r;
  logic out_valid_r, out_valid_nxt;
  cpl_t out_cpl_r;
  logic out_take;
  logic s1_move;
  logic in_fire;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  nvc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.reg_index),
    .wr_data  (cfg_ch.wr_data),
    .cfg      (cfg)
  );

  // pipeline flow control
  assign out_take    = !out_valid_r || out_ch.ready;
  assign s1_move     = s1_valid_r && out_take;
  assign in_ch.ready = !s1_valid_r || out_take;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign in_cmd.opcode           = in_ch.opcode;
  assign in_cmd.command_id       = in_ch.command_id;
  assign in_cmd.first_lba        = in_ch.first_lba;
  assign in_cmd.blocks_minus_one = in_ch.blocks_minus_one;
  assign in_cmd.buffer_address   = in_ch.buffer_address;

  // queue pointers advance as a command leaves the input register
  nvc_queue_ptrs u_ptrs (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (s1_move),
    .sq_depth (cfg.submission_depth),
    .cq_depth (cfg.completion_depth),
    .ptrs     (ptrs)
  );

  nvc_cmd_eval u_eval (
    .cmd  (s1_cmd_r),
    .cfg  (cfg),
    .ptrs (ptrs),
    .cpl  (cpl)
  );

  // valid bits
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_ch.ready) begin
      s1_valid_nxt = in_fire;
    end
    if (out_take) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= in_cmd;
    end
    if (s1_move) begin
      out_cpl_r <= cpl;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.completion_slot   = out_cpl_r.completion_slot;
  assign out_ch.head_report       = out_cpl_r.head_report;
  assign out_ch.echo_id           = out_cpl_r.echo_id;
  assign out_ch.status            = out_cpl_r.status;
  assign out_ch.phase             = out_cpl_r.phase;
  assign out_ch.dma_direction     = out_cpl_r.dma_direction;
  assign out_ch.dma_host_address  = out_cpl_r.dma_host_address;
  assign out_ch.dma_device_offset = out_cpl_r.dma_device_offset;
  assign out_ch.dma_length        = out_cpl_r.dma_length;
endmodule

### rtl/nvc_checker.sv
module nvc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [nvc_pkg::STATUS_W-1:0] status,
  input logic [nvc_pkg::DIR_W-1:0]    dma_direction,
  input logic [nvc_pkg::LENGTH_W-1:0] dma_length,
  input logic [nvc_pkg::PTR_W-1:0]    completion_slot
);
  import nvc_pkg::*;

  // a stalled completion holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(completion_slot) && $stable(status))
    else $error("completion changed while stalled");

  // failed commands issue no transfer
  a_fail_no_dma: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |-> (dma_direction == DIR_NONE) && (dma_length == '0))
    else $error("transfer issued for a failed command");

  // a transfer only follows a successful command
  a_dma_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (dma_direction != DIR_NONE) |-> (status == ST_OK))
    else $error("transfer without success");

  // status and direction stay within their codes
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == ST_OK || status == ST_BAD_OPCODE || status == ST_BAD_FIELD) &&
                  (dma_direction == DIR_NONE || dma_direction == DIR_TO_HOST ||
                   dma_direction == DIR_TO_DEV))
    else $error("unused status or direction code");
endmodule

bind nvme_io_command_completer nvc_checker u_nvc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .status          (out_ch.status),
  .dma_direction   (out_ch.dma_direction),
  .dma_length      (out_ch.dma_length),
  .completion_slot (out_ch.completion_slot)
);
